[design/lfps_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfps_pkg
// Shared widths, register indexes, reset values, the sensor weight table and
// the stage payload types of the line-follow PID steering unit.
// ----------------------------------------------------------------------------
package lfps_pkg;

  // Field and datapath widths.
  localparam int CODE_W    = 3;
  localparam int BASE_W    = 8;
  localparam int GAIN_W    = 26;
  localparam int CENTER_W  = 11;
  localparam int TICKS_W   = 16;
  localparam int SPEED_W   = 8;
  localparam int ERR_W     = 11;
  localparam int DERIV_W   = 12;
  localparam int SUM_W     = 40;
  localparam int HALF_W    = SUM_W / 2;
  localparam int PP_W      = GAIN_W + HALF_W;
  localparam int IPROD_W   = GAIN_W + SUM_W;
  localparam int PTERM_W   = GAIN_W + 1 + ERR_W;
  localparam int DTERM_W   = GAIN_W + 1 + DERIV_W;
  localparam int ITERM_W   = 42;
  localparam int CORR_W    = 43;
  localparam int Q_W       = 44;
  localparam int FRAC_BITS = 24;
  localparam int WEIGHT_W  = 12;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = GAIN_W;

  localparam logic [CFG_IDX_W-1:0] REG_NOMINAL_SPEED   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P          = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I          = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D          = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_POS      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LOST_TURN_TICKS = 3'd5;

  // Register reset values.
  localparam logic signed [BASE_W-1:0] RST_NOMINAL_SPEED   = 8'sd50;
  localparam logic [GAIN_W-1:0]        RST_GAIN_P          = 26'd2013266;
  localparam logic [GAIN_W-1:0]        RST_GAIN_I          = 26'd117;
  localparam logic [GAIN_W-1:0]        RST_GAIN_D          = 26'd335544;
  localparam logic [CENTER_W-1:0]      RST_CENTER_POS      = 11'd1000;
  localparam logic [TICKS_W-1:0]       RST_LOST_TURN_TICKS = 16'd300;

  // Error limits and special values.
  localparam logic [CODE_W-1:0]         CODE_LOST = 3'd0;
  localparam logic signed [ERR_W-1:0]   LOST_NEG  = -11'sd1000;
  localparam logic signed [ERR_W-1:0]   LOST_POS  = 11'sd1000;
  localparam logic signed [ERR_W-1:0]   ERR_MAX   = 11'sd1023;
  localparam logic signed [ERR_W-1:0]   ERR_MIN   = -11'sd1024;
  localparam logic signed [SUM_W-1:0]   SUM_MAX   = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0]   SUM_MIN   = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic [IPROD_W-1:0]        ITERM_LIMIT = 66'd1 << 40;
  localparam logic signed [SPEED_W-1:0] SPEED_MAX = 8'sd100;
  localparam logic signed [SPEED_W-1:0] SPEED_MIN = -8'sd100;
  localparam logic [TICKS_W-1:0]        TICKS_TOP = '1;

  // Sensor code to line position weight.
  localparam logic signed [WEIGHT_W-1:0] WEIGHT_TAB [8] = '{
    -12'sd1, 12'sd2000, 12'sd1000, 12'sd1500, 12'sd0, -12'sd2, 12'sd500, 12'sd1000
  };

  // Configuration register set.
  typedef struct packed {
    logic signed [BASE_W-1:0] nominal_speed;
    logic [GAIN_W-1:0]        gain_p;
    logic [GAIN_W-1:0]        gain_i;
    logic [GAIN_W-1:0]        gain_d;
    logic [CENTER_W-1:0]      center_pos;
    logic [TICKS_W-1:0]       lost_turn_ticks;
  } cfg_t;

  // Error stage payload: error, derivative and integral magnitude.
  typedef struct packed {
    logic signed [ERR_W-1:0]   err;
    logic signed [DERIV_W-1:0] deriv;
    logic [SUM_W-1:0]          mag;
    logic                      neg;
    logic                      obst;
  } err_stg_t;

  // Multiplier stage payload.
  typedef struct packed {
    logic signed [PTERM_W-1:0] p_term;
    logic signed [DTERM_W-1:0] d_term;
    logic [PP_W-1:0]           pp_lo;
    logic [PP_W-1:0]           pp_hi;
    logic                      neg;
    logic                      obst;
  } mul_stg_t;

  // Integral stage payload.
  typedef struct packed {
    logic signed [CORR_W-1:0]  pd_sum;
    logic signed [ITERM_W-1:0] i_term;
    logic                      obst;
  } int_stg_t;

endpackage

[design/lfps_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfps_in_if / lfps_out_if
// Valid/ready channels for sensor items in and motor speed items out.
// ----------------------------------------------------------------------------
interface lfps_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] line_code;
  logic       obstacle;

  modport source (output valid, output line_code, output obstacle, input ready);
  modport sink (input valid, input line_code, input obstacle, output ready);
endinterface

interface lfps_out_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] left_speed;
  logic signed [7:0] right_speed;

  modport source (output valid, output left_speed, output right_speed, input ready);
  modport sink (input valid, input left_speed, input right_speed, output ready);
endinterface

[design/lfps_cfg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfps_cfg
// Configuration register file written through a plain write port.
// ----------------------------------------------------------------------------
module lfps_cfg import lfps_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                  cfg
);

  // Registers load on a write to their index; other indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.nominal_speed   <= RST_NOMINAL_SPEED;
      cfg.gain_p          <= RST_GAIN_P;
      cfg.gain_i          <= RST_GAIN_I;
      cfg.gain_d          <= RST_GAIN_D;
      cfg.center_pos      <= RST_CENTER_POS;
      cfg.lost_turn_ticks <= RST_LOST_TURN_TICKS;
    end else if (wr_en) begin
      case (wr_index)
        REG_NOMINAL_SPEED:   cfg.nominal_speed   <= $signed(wr_data[BASE_W-1:0]);
        REG_GAIN_P:          cfg.gain_p          <= wr_data;
        REG_GAIN_I:          cfg.gain_i          <= wr_data;
        REG_GAIN_D:          cfg.gain_d          <= wr_data;
        REG_CENTER_POS:      cfg.center_pos      <= wr_data[CENTER_W-1:0];
        REG_LOST_TURN_TICKS: cfg.lost_turn_ticks <= wr_data[TICKS_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

[design/lfps_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfps_front
// Input stage: forms the line error, updates the integral, last error and
// tick counter, and registers the error terms for the multipliers.
// ----------------------------------------------------------------------------
module lfps_front import lfps_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  lfps_in_if.sink     sensor,
  output logic        stg_valid,
  output err_stg_t    stg,
  input  logic        stg_ready
);

  logic signed [SUM_W-1:0]   error_sum;
  logic signed [ERR_W-1:0]   last_error;
  logic [TICKS_W-1:0]        tick_count;

  logic signed [WEIGHT_W:0]  diff;
  logic signed [ERR_W-1:0]   err;
  logic signed [SUM_W:0]     sum_wide;
  logic signed [SUM_W-1:0]   sum_sat;
  logic signed [SUM_W:0]     mag_wide;
  logic                      accept;
  err_stg_t                  stg_next;

  assign sensor.ready = !stg_valid || stg_ready;
  assign accept       = sensor.valid && sensor.ready;

  // Line error: weight minus center, or the lost-line turn value.
  always_comb begin
    diff = (WEIGHT_W+1)'(WEIGHT_TAB[sensor.line_code]) - $signed({2'b00, cfg.center_pos});
    if (sensor.line_code == CODE_LOST) begin
      err = (tick_count < cfg.lost_turn_ticks) ? LOST_NEG : LOST_POS;
    end else if (diff > (WEIGHT_W+1)'(ERR_MAX)) begin
      err = ERR_MAX;
    end else if (diff < (WEIGHT_W+1)'(ERR_MIN)) begin
      err = ERR_MIN;
    end else begin
      err = diff[ERR_W-1:0];
    end
  end

  // Saturating integral and its magnitude for the split multiplier.
  always_comb begin
    sum_wide = $signed({error_sum[SUM_W-1], error_sum}) + (SUM_W+1)'(err);
    if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
      sum_sat = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_sat = sum_wide[SUM_W-1:0];
    end
    mag_wide = sum_sat[SUM_W-1] ? -$signed({sum_sat[SUM_W-1], sum_sat})
                                : $signed({sum_sat[SUM_W-1], sum_sat});
    stg_next.err   = err;
    stg_next.deriv = DERIV_W'(err) - DERIV_W'(last_error);
    stg_next.mag   = mag_wide[SUM_W-1:0];
    stg_next.neg   = sum_sat[SUM_W-1];
    stg_next.obst  = sensor.obstacle;
  end

  // Controller state advances on every accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      error_sum  <= '0;
      last_error <= '0;
      tick_count <= '0;
    end else if (accept) begin
      error_sum  <= sensor.obstacle ? '0 : sum_sat;
      last_error <= err;
      if (tick_count != TICKS_TOP) begin
        tick_count <= tick_count + TICKS_W'(1);
      end
    end
  end

  // Stage register.
  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (sensor.ready) begin
      stg_valid <= sensor.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stg <= stg_next;
    end
  end

endmodule

[design/lfps_mult.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfps_mult
// Multiplier stage: proportional and derivative products, and the integral
// product as two partial products over the halves of its magnitude.
// ----------------------------------------------------------------------------
module lfps_mult import lfps_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  cfg_t     cfg,
  input  logic     src_valid,
  input  err_stg_t src,
  output logic     src_ready,
  output logic     stg_valid,
  output mul_stg_t stg,
  input  logic     stg_ready
);

  mul_stg_t stg_next;

  assign src_ready = !stg_valid || stg_ready;

  // Four independent products, each no wider than 27 by 20 bits.
  always_comb begin
    stg_next.p_term = $signed({1'b0, cfg.gain_p}) * src.err;
    stg_next.d_term = $signed({1'b0, cfg.gain_d}) * src.deriv;
    stg_next.pp_lo  = cfg.gain_i * src.mag[HALF_W-1:0];
    stg_next.pp_hi  = cfg.gain_i * src.mag[SUM_W-1:HALF_W];
    stg_next.neg    = src.neg;
    stg_next.obst   = src.obst;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (src_ready) begin
      stg_valid <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (src_ready && src_valid) begin
      stg <= stg_next;
    end
  end

endmodule

[design/lfps_iterm.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfps_iterm
// Integral stage: joins the partial products, limits the integral term and
// restores its sign; adds the proportional and derivative terms alongside.
// ----------------------------------------------------------------------------
module lfps_iterm import lfps_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     src_valid,
  input  mul_stg_t src,
  output logic     src_ready,
  output logic     stg_valid,
  output int_stg_t stg,
  input  logic     stg_ready
);

  logic [IPROD_W-1:0]  iprod;
  logic [ITERM_W-2:0]  imag;
  int_stg_t            stg_next;

  assign src_ready = !stg_valid || stg_ready;

  // Integral magnitude limited at 2^40 in Q24, then signed.
  always_comb begin
    iprod = IPROD_W'(src.pp_lo) + (IPROD_W'(src.pp_hi) << HALF_W);
    imag  = (iprod > ITERM_LIMIT) ? ITERM_LIMIT[ITERM_W-2:0] : iprod[ITERM_W-2:0];
    stg_next.i_term = src.neg ? -$signed({1'b0, imag}) : $signed({1'b0, imag});
    stg_next.pd_sum = CORR_W'(src.p_term) + CORR_W'(src.d_term);
    stg_next.obst   = src.obst;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (src_ready) begin
      stg_valid <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (src_ready && src_valid) begin
      stg <= stg_next;
    end
  end

endmodule

[design/lfps_out.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfps_out
// Output stages: forms base plus and minus the correction, then truncates
// toward zero, clamps to the speed range and holds the result item.
// ----------------------------------------------------------------------------
module lfps_out import lfps_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       src_valid,
  input  int_stg_t   src,
  output logic       src_ready,
  lfps_out_if.source motor
);

  logic signed [Q_W-1:0]    base_q;
  logic signed [CORR_W-1:0] corr;
  logic                     q_valid;
  logic                     q_ready;
  logic signed [Q_W-1:0]    q_left;
  logic signed [Q_W-1:0]    q_right;
  logic                     q_obst;

  // Truncate a Q24 value toward zero and clamp it to the speed range.
  function automatic logic signed [SPEED_W-1:0] to_speed(input logic signed [Q_W-1:0] q);
    logic signed [Q_W-FRAC_BITS:0] v;
    begin
      v = (Q_W-FRAC_BITS+1)'($signed(q[Q_W-1:FRAC_BITS]));
      if (q[Q_W-1] && (q[FRAC_BITS-1:0] != '0)) begin
        v = v + (Q_W-FRAC_BITS+1)'(1);
      end
      if (v > (Q_W-FRAC_BITS+1)'(SPEED_MAX)) begin
        to_speed = SPEED_MAX;
      end else if (v < (Q_W-FRAC_BITS+1)'(SPEED_MIN)) begin
        to_speed = SPEED_MIN;
      end else begin
        to_speed = v[SPEED_W-1:0];
      end
    end
  endfunction

  assign q_ready   = !motor.valid || motor.ready;
  assign src_ready = !q_valid || q_ready;

  // Sum stage: full correction and both side sums in Q24.
  always_comb begin
    base_q = Q_W'(cfg.nominal_speed) <<< FRAC_BITS;
    corr   = src.pd_sum + CORR_W'(src.i_term);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (src_ready) begin
      q_valid <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (src_ready && src_valid) begin
      q_left  <= base_q + Q_W'(corr);
      q_right <= base_q - Q_W'(corr);
      q_obst  <= src.obst;
    end
  end

  // Result register; an obstacle stops both motors.
  always_ff @(posedge clk) begin
    if (rst) begin
      motor.valid <= 1'b0;
    end else if (q_ready) begin
      motor.valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (q_ready && q_valid) begin
      motor.left_speed  <= q_obst ? '0 : to_speed(q_left);
      motor.right_speed <= q_obst ? '0 : to_speed(q_right);
    end
  end

endmodule

[design/line_follow_pid_steering_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_follow_pid_steering_unit
// PID steering for a differential-drive line follower.
// ----------------------------------------------------------------------------
// Each item on the sensor channel is one control tick: a 3-bit line code and
// an obstacle flag. Each tick gives exactly one item on the motor channel
// with the signed left and right speed commands, in the order of the ticks.
// Gains and the other settings are loaded through the write port
// (wr_en, wr_index, wr_data) while no tick is in flight.
// The unit is a five-stage pipeline and takes one tick per cycle unless the
// motor side stalls. A result passes the error, multiplier, integral, sum and
// result registers in turn. The integral, last error and tick counter update
// in the input stage, so ticks may follow each other in consecutive cycles.
// The integral product is split into two 26x20 partial products that are
// joined one stage later; that, and the final add and clamp, set the depth.
// Reset loads the default settings, clears the integral, last error and tick
// counter, and empties the pipeline. When the motor side stalls, each stage
// keeps accepting until it is full, so up to five ticks are held before the
// sensor channel's ready drops.
// ----------------------------------------------------------------------------
module line_follow_pid_steering_unit import lfps_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  lfps_in_if.sink               sensor,
  lfps_out_if.source            motor,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data
);

  cfg_t     cfg;
  logic     err_valid;
  logic     err_ready;
  err_stg_t err_stg;
  logic     mul_valid;
  logic     mul_ready;
  mul_stg_t mul_stg;
  logic     int_valid;
  logic     int_ready;
  int_stg_t int_stg;

  lfps_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  lfps_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .sensor    (sensor),
    .stg_valid (err_valid),
    .stg       (err_stg),
    .stg_ready (err_ready)
  );

  lfps_mult u_mult (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .src_valid (err_valid),
    .src       (err_stg),
    .src_ready (err_ready),
    .stg_valid (mul_valid),
    .stg       (mul_stg),
    .stg_ready (mul_ready)
  );

  lfps_iterm u_iterm (
    .clk       (clk),
    .rst       (rst),
    .src_valid (mul_valid),
    .src       (mul_stg),
    .src_ready (mul_ready),
    .stg_valid (int_valid),
    .stg       (int_stg),
    .stg_ready (int_ready)
  );

  lfps_out u_out (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .src_valid (int_valid),
    .src       (int_stg),
    .src_ready (int_ready),
    .motor     (motor)
  );

endmodule

[dv/tb_line_follow_pid_steering_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_line_follow_pid_steering_unit
// Self-checking bench for the line-follow PID steering unit.
// ----------------------------------------------------------------------------
// Sensor ticks go in over a valid/ready channel and every accepted tick is
// run through a cycle-free model of the controller (weight lookup, lost-line
// turn, saturating integral, Q24 PID sum, truncation and clamp). The motor
// channel is checked item by item against the oldest predicted speed pair.
// Settings are reloaded between phases while the unit is empty, covering the
// extreme values, and a short no-idle stretch at the end runs lost-line
// ticks across a turn point.
// ----------------------------------------------------------------------------
module tb_line_follow_pid_steering_unit;
  import lfps_pkg::*;

  localparam longint SUM_TOP     = (64'sd1 <<< (SUM_W - 1)) - 1;
  localparam longint SUM_BOTTOM  = -(64'sd1 <<< (SUM_W - 1));
  localparam longint ITERM_CAP   = 64'sd1 <<< 40;
  localparam int     PIPE_DEPTH  = 5;
  localparam int     LONG_HOLD   = 40;
  localparam int     PHASES      = 7;
  localparam int     PHASE_ITEMS = 200;
  localparam int     TAIL_ITEMS  = 40;

  typedef struct {
    logic signed [SPEED_W-1:0] left;
    logic signed [SPEED_W-1:0] right;
  } speed_pair_t;

  // Tracks the controller state and holds the speed pairs still to arrive.
  class steering_scoreboard;
    logic signed [BASE_W-1:0] nominal;
    logic [GAIN_W-1:0]        gain_p;
    logic [GAIN_W-1:0]        gain_i;
    logic [GAIN_W-1:0]        gain_d;
    logic [CENTER_W-1:0]      center;
    logic [TICKS_W-1:0]       lost_ticks;
    logic signed [SUM_W-1:0]  err_sum;
    logic signed [ERR_W-1:0]  prev_err;
    logic [TICKS_W-1:0]       ticks;
    speed_pair_t              pending_speeds[$];
    int unsigned              mismatches;

    function new();
      nominal    = RST_NOMINAL_SPEED;
      gain_p     = RST_GAIN_P;
      gain_i     = RST_GAIN_I;
      gain_d     = RST_GAIN_D;
      center     = RST_CENTER_POS;
      lost_ticks = RST_LOST_TURN_TICKS;
      err_sum    = '0;
      prev_err   = '0;
      ticks      = '0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_NOMINAL_SPEED:   nominal    = data[BASE_W-1:0];
        REG_GAIN_P:          gain_p     = data[GAIN_W-1:0];
        REG_GAIN_I:          gain_i     = data[GAIN_W-1:0];
        REG_GAIN_D:          gain_d     = data[GAIN_W-1:0];
        REG_CENTER_POS:      center     = data[CENTER_W-1:0];
        REG_LOST_TURN_TICKS: lost_ticks = data[TICKS_W-1:0];
        default: ;
      endcase
    endfunction

    // Q24 value to a whole speed: truncate toward zero, then clamp.
    function logic signed [SPEED_W-1:0] to_speed(longint q);
      longint v;
      v = (q < 0) ? -((-q) >>> FRAC_BITS) : (q >>> FRAC_BITS);
      if (v > SPEED_MAX) v = SPEED_MAX;
      if (v < SPEED_MIN) v = SPEED_MIN;
      return SPEED_W'(v);
    endfunction

    // One control tick: update the state and queue the speeds it produces.
    function void note_tick(logic [CODE_W-1:0] code, logic obst);
      int          e;
      int          d;
      longint      s;
      longint      mag;
      longint      it;
      longint      gp;
      longint      gi;
      longint      gd;
      longint      qb;
      longint      corr;
      speed_pair_t p;
      case (code)
        3'd1:    e = 2000;
        3'd2:    e = 1000;
        3'd3:    e = 1500;
        3'd4:    e = 0;
        3'd5:    e = -2;
        3'd6:    e = 500;
        3'd7:    e = 1000;
        default: e = -1;
      endcase
      e = e - int'(center);
      // A lost line turns one way until enough ticks have passed.
      if (code == CODE_LOST) e = (ticks < lost_ticks) ? -1000 : 1000;
      if (e > 1023) e = 1023;
      if (e < -1024) e = -1024;

      s = longint'(err_sum) + e;
      if (s > SUM_TOP) s = SUM_TOP;
      if (s < SUM_BOTTOM) s = SUM_BOTTOM;
      err_sum  = SUM_W'(s);
      d        = e - int'(prev_err);
      prev_err = ERR_W'(e);

      if (obst) begin
        err_sum = '0;
        p.left  = '0;
        p.right = '0;
      end else begin
        gp  = gain_p;
        gi  = gain_i;
        gd  = gain_d;
        // Integral term magnitude is capped before the sign goes back on.
        mag = (s < 0) ? -s : s;
        if (gi == 0 || mag == 0) it = 0;
        else if (mag > ITERM_CAP / gi) it = ITERM_CAP;
        else it = mag * gi;
        if (s < 0) it = -it;
        corr    = gp * e + it + gd * d;
        qb      = longint'(nominal) * (64'sd1 <<< FRAC_BITS);
        p.left  = to_speed(qb + corr);
        p.right = to_speed(qb - corr);
      end

      if (ticks != TICKS_TOP) ticks++;
      pending_speeds.push_back(p);
    endfunction

    function void log_miss(string field, logic signed [SPEED_W-1:0] want,
                           logic signed [SPEED_W-1:0] got);
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endfunction

    function void check_speeds(logic signed [SPEED_W-1:0] l, logic signed [SPEED_W-1:0] r);
      speed_pair_t w;
      if (pending_speeds.size() == 0) begin
        mismatches++;
        $display("%0t: speed item with no tick pending, expected none, actual %0d/%0d",
                 $time, l, r);
        return;
      end
      w = pending_speeds.pop_front();
      if (l !== w.left) log_miss("left_speed", w.left, l);
      if (r !== w.right) log_miss("right_speed", w.right, r);
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  wr_en;
  logic [CFG_IDX_W-1:0]  wr_index;
  logic [CFG_DATA_W-1:0] wr_data;
  bit                    idle_on;
  bit                    hold_request;
  int                    run_left;
  logic [CODE_W-1:0]     run_code;

  steering_scoreboard tracker = new();

  lfps_in_if  sensor_ch ();
  lfps_out_if motor_ch ();

  line_follow_pid_steering_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .sensor   (sensor_ch),
    .motor    (motor_ch),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Run limit, far above the slowest legal run.
  initial begin
    #600_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Motor side: check accepted items, then pick ready for the next cycle.
  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    motor_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && motor_ch.valid && motor_ch.ready)
        tracker.check_speeds(motor_ch.left_speed, motor_ch.right_speed);
      @(negedge clk);
      if (hold_request) begin
        hold_left    = LONG_HOLD;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        motor_ch.ready = 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        motor_ch.ready = 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        motor_ch.ready = 1'b0;
        stall_left = $urandom_range(0, 6);
      end else begin
        motor_ch.ready = 1'b1;
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    wr_en    = 1'b1;
    wr_index = idx;
    wr_data  = data;
    @(negedge clk);
    wr_en = 1'b0;
    tracker.set_reg(idx, data);
  endtask

  // Offer one tick, with an optional idle gap in front, until it is taken.
  task automatic send_tick(input logic [CODE_W-1:0] code, input logic obst);
    int gap;
    gap = (idle_on && $urandom_range(0, 7) == 0) ? $urandom_range(1, 7) : 0;
    if (gap > 0) begin
      @(negedge clk);
      sensor_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    sensor_ch.valid     = 1'b1;
    sensor_ch.line_code = code;
    sensor_ch.obstacle  = obst;
    do @(posedge clk); while (!sensor_ch.ready);
    tracker.note_tick(code, obst);
  endtask

  // Runs of one sensor code build up the integral; some codes break the run.
  task automatic send_random_tick();
    logic [CODE_W-1:0] code;
    if (run_left == 0) begin
      run_code = CODE_W'($urandom_range(0, 7));
      run_left = $urandom_range(1, 24);
    end
    run_left--;
    code = ($urandom_range(0, 5) == 0) ? CODE_W'($urandom_range(0, 7)) : run_code;
    send_tick(code, $urandom_range(0, 15) == 0);
  endtask

  // Stop offering and let every predicted item come out of the pipeline.
  task automatic wait_for_results();
    @(negedge clk);
    sensor_ch.valid = 1'b0;
    while (tracker.pending_speeds.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 3) @(posedge clk);
  endtask

  function automatic logic [GAIN_W-1:0] pick_gain(logic [GAIN_W-1:0] dflt);
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return '1;
      2:       return dflt;
      3:       return GAIN_W'($urandom());
      default: return GAIN_W'($urandom_range(0, 1 << 22));
    endcase
  endfunction

  // Load every register with an extreme, default or random value.
  task automatic apply_random_settings();
    logic signed [BASE_W-1:0] b;
    logic [CENTER_W-1:0]      c;
    logic [TICKS_W-1:0]       lt;
    case ($urandom_range(0, 3))
      0:       b = SPEED_MAX;
      1:       b = SPEED_MIN;
      2:       b = RST_NOMINAL_SPEED;
      default: b = BASE_W'(int'($urandom_range(0, 200)) - 100);
    endcase
    case ($urandom_range(0, 3))
      0:       c = '0;
      1:       c = '1;
      2:       c = RST_CENTER_POS;
      default: c = CENTER_W'($urandom_range(0, 2047));
    endcase
    // A turn point just ahead of the tick count flips the lost-line error.
    case ($urandom_range(0, 3))
      0:       lt = '0;
      1:       lt = '1;
      2:       lt = RST_LOST_TURN_TICKS;
      default: lt = tracker.ticks + TICKS_W'($urandom_range(0, 250));
    endcase
    write_reg(REG_NOMINAL_SPEED, {{(CFG_DATA_W - BASE_W){1'b0}}, b});
    write_reg(REG_GAIN_P, pick_gain(RST_GAIN_P));
    write_reg(REG_GAIN_I, pick_gain(RST_GAIN_I));
    write_reg(REG_GAIN_D, pick_gain(RST_GAIN_D));
    write_reg(REG_CENTER_POS, CFG_DATA_W'(c));
    write_reg(REG_LOST_TURN_TICKS, CFG_DATA_W'(lt));
  endtask

  // Main sequence.
  initial begin
    rst                 = 1'b1;
    wr_en               = 1'b0;
    wr_index            = '0;
    wr_data             = '0;
    sensor_ch.valid     = 1'b0;
    sensor_ch.line_code = '0;
    sensor_ch.obstacle  = 1'b0;
    idle_on             = 1'b1;
    hold_request        = 1'b0;
    run_left            = 0;
    run_code            = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Default settings: every code once, the lost line before the turn
    // point, and an obstacle that clears the integral.
    for (int k = 0; k < 8; k++) send_tick(CODE_W'(k), k == 7);
    wait_for_results();

    // High extremes: the lost line past a zero turn point, errors clipped at
    // the top, and an integral big enough to hit the product cap.
    write_reg(REG_NOMINAL_SPEED, CFG_DATA_W'(8'd100));
    write_reg(REG_GAIN_P, '1);
    write_reg(REG_GAIN_I, '1);
    write_reg(REG_GAIN_D, '1);
    write_reg(REG_CENTER_POS, '0);
    write_reg(REG_LOST_TURN_TICKS, '0);
    send_tick(CODE_LOST, 1'b0);
    repeat (16) send_tick(3'd1, 1'b0);
    wait_for_results();

    // Low extremes: errors clipped at the bottom, zero gains, far turn point.
    write_reg(REG_NOMINAL_SPEED, {{(CFG_DATA_W - BASE_W){1'b0}}, SPEED_MIN});
    write_reg(REG_GAIN_P, '0);
    write_reg(REG_GAIN_I, '0);
    write_reg(REG_GAIN_D, '0);
    write_reg(REG_CENTER_POS, CFG_DATA_W'(11'd2047));
    write_reg(REG_LOST_TURN_TICKS, CFG_DATA_W'(16'hFFFF));
    send_tick(3'd5, 1'b0);
    send_tick(CODE_LOST, 1'b1);
    wait_for_results();

    // Random phases, each under new settings.
    for (int ph = 0; ph < PHASES; ph++) begin
      apply_random_settings();
      idle_on = (ph < 3) || ($urandom_range(0, 3) != 0);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == 1 && i == PHASE_ITEMS / 2) hold_request = 1'b1;
        if (ph == 2 && i == PHASE_ITEMS / 2) wait_for_results();
        send_random_tick();
      end
      wait_for_results();
    end

    // Back-to-back ticks with no idling; lost-line ticks straddle a turn
    // point placed in the middle of the stretch so both sides of it are seen.
    idle_on = 1'b0;
    apply_random_settings();
    write_reg(REG_LOST_TURN_TICKS,
              CFG_DATA_W'(tracker.ticks + TICKS_W'(TAIL_ITEMS / 2)));
    for (int n = 0; n < TAIL_ITEMS; n++) begin
      if (n >= TAIL_ITEMS / 2 - 5 && n <= TAIL_ITEMS / 2 + 5) send_tick(CODE_LOST, 1'b0);
      else send_random_tick();
    end
    wait_for_results();
    repeat (10) @(posedge clk);

    if (tracker.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
